// File: design/urtb_pkg.sv
package urtb_pkg;

  // default number of slots per ring queue
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // request operation codes
  localparam logic [1:0] OP_LINE_RX  = 2'd0;
  localparam logic [1:0] OP_HOST_RD  = 2'd1;
  localparam logic [1:0] OP_HOST_WR  = 2'd2;
  localparam logic [1:0] OP_TX_READY = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_NO_DATA  = 3'd5;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;
    logic emit;
  } cmd_t;

endpackage

// File: design/uart_rx_tx_ring_buffers.sv
// UART receive and transmit byte ring queues.
// One request channel: a request (operation, data_byte, framing_error,
// overrun_error) is taken at a rising edge with start high and busy low.
// Operations: line byte received, host read, host write, transmitter ready.
// Each request gives exactly one result on read_data, status, rx_count,
// tx_valid, tx_byte, tx_irq_enable and write_accepted, shown for one cycle
// with done high, in the cycle right after the request is taken.
// A new request is not taken while busy: the request cycle updates the
// pointers and writes or reads the queue memory, whose registered read
// data is shown in the following result cycle, during which busy is high.
// Each queue keeps one slot free, so it holds QUEUE_DEPTH - 1 bytes.
// Reset (synchronous, rst high) empties both queues, clears the latched
// error and the transmit interrupt enable; memory contents are not cleared
// and need no clearing pass, since only occupied slots are ever read.
// The receiver cannot stall: results must be taken in their done cycle.
module uart_rx_tx_ring_buffers #(
  parameter int unsigned QUEUE_DEPTH = urtb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] data_byte,
  input  logic       framing_error,
  input  logic       overrun_error,
  output logic       done,
  output logic [7:0] read_data,
  output logic [2:0] status,
  output logic [3:0] rx_count,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       tx_irq_enable,
  output logic       write_accepted
);

  urtb_pkg::cmd_t cmd;

  // sequencer
  urtb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // queues, pointers and result registers
  urtb_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operation      (operation),
    .data_byte      (data_byte),
    .framing_error  (framing_error),
    .overrun_error  (overrun_error),
    .read_data      (read_data),
    .status         (status),
    .rx_count       (rx_count),
    .tx_valid       (tx_valid),
    .tx_byte        (tx_byte),
    .tx_irq_enable  (tx_irq_enable),
    .write_accepted (write_accepted)
  );

  assign done = cmd.emit;

  // a result follows exactly one taken request
  a_done_after_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without a request");

  // result cycle lasts one cycle
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held beyond one cycle");

  // a stored host write turns the transmit interrupt on
  a_wr_irq: assert property (@(posedge clk) disable iff (rst)
    (done && write_accepted) |-> tx_irq_enable)
    else $error("accepted write left interrupt off");

  // a transmitted byte comes with ok status and no host read data
  a_tx_ok: assert property (@(posedge clk) disable iff (rst)
    (done && tx_valid) |-> (status == urtb_pkg::ST_OK && read_data == 8'h00))
    else $error("transmit result carries read status");

endmodule

// File: design/urtb_ctrl.sv
module urtb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output urtb_pkg::cmd_t cmd
);

  urtb_pkg::state_t state;
  urtb_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urtb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      urtb_pkg::S_IDLE: begin
        if (start) state_next = urtb_pkg::S_RESP;
      end
      urtb_pkg::S_RESP: begin
        state_next = urtb_pkg::S_IDLE;
      end
      default: state_next = urtb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b0;
    cmd.exec = 1'b0;
    cmd.emit = 1'b0;
    case (state)
      urtb_pkg::S_IDLE: begin
        cmd.exec = start;
      end
      urtb_pkg::S_RESP: begin
        busy     = 1'b1;
        cmd.emit = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

// File: design/urtb_dpath.sv
module urtb_dpath #(
  parameter int unsigned QUEUE_DEPTH = urtb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  urtb_pkg::cmd_t cmd,
  input  logic [1:0]     operation,
  input  logic [7:0]     data_byte,
  input  logic           framing_error,
  input  logic           overrun_error,
  output logic [7:0]     read_data,
  output logic [2:0]     status,
  output logic [3:0]     rx_count,
  output logic           tx_valid,
  output logic [7:0]     tx_byte,
  output logic           tx_irq_enable,
  output logic           write_accepted
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  logic [7:0] rx_store [QUEUE_DEPTH];
  logic [7:0] tx_store [QUEUE_DEPTH];

  logic [PW-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [PW-1:0] rx_head_next, rx_tail_next, tx_head_next, tx_tail_next;
  logic [2:0]    last_error, last_error_next;
  logic          tx_irq_on, tx_irq_on_next;

  logic [PW-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
  logic          rx_empty, rx_full, tx_empty, tx_full;
  logic          rx_wr, rx_rd, tx_wr, tx_rd;
  logic [2:0]    status_next;
  logic [PW:0]   count_next;

  logic [7:0]    rx_rdata, tx_rdata;
  logic          rd_sel, tx_sel;

  // pointer advance with wrap at depth
  always_comb begin
    rx_head_inc = (rx_head == LAST) ? '0 : rx_head + PW'(1);
    rx_tail_inc = (rx_tail == LAST) ? '0 : rx_tail + PW'(1);
    tx_head_inc = (tx_head == LAST) ? '0 : tx_head + PW'(1);
    tx_tail_inc = (tx_tail == LAST) ? '0 : tx_tail + PW'(1);
  end

  assign rx_empty = (rx_head == rx_tail);
  assign rx_full  = (rx_head_inc == rx_tail);
  assign tx_empty = (tx_head == tx_tail);
  assign tx_full  = (tx_head_inc == tx_tail);

  // request decode and state update
  always_comb begin
    rx_head_next    = rx_head;
    rx_tail_next    = rx_tail;
    tx_head_next    = tx_head;
    tx_tail_next    = tx_tail;
    last_error_next = last_error;
    tx_irq_on_next  = tx_irq_on;
    status_next     = urtb_pkg::ST_OK;
    rx_wr = 1'b0;
    rx_rd = 1'b0;
    tx_wr = 1'b0;
    tx_rd = 1'b0;
    case (operation)
      urtb_pkg::OP_LINE_RX: begin
        if (rx_full) begin
          last_error_next = urtb_pkg::ST_OVERFLOW;
        end else begin
          last_error_next = {1'b0, overrun_error, framing_error};
          rx_head_next    = rx_head_inc;
          rx_wr           = 1'b1;
        end
        status_next = last_error_next;
      end
      urtb_pkg::OP_HOST_RD: begin
        if (rx_empty) begin
          status_next = urtb_pkg::ST_NO_DATA;
        end else begin
          rx_tail_next = rx_tail_inc;
          rx_rd        = 1'b1;
          status_next  = last_error;
        end
      end
      urtb_pkg::OP_HOST_WR: begin
        if (!tx_full) begin
          tx_head_next   = tx_head_inc;
          tx_irq_on_next = 1'b1;
          tx_wr          = 1'b1;
        end
      end
      urtb_pkg::OP_TX_READY: begin
        if (!tx_empty) begin
          tx_tail_next = tx_tail_inc;
          tx_rd        = 1'b1;
        end else begin
          tx_irq_on_next = 1'b0;
        end
      end
      default: status_next = urtb_pkg::ST_OK;
    endcase
  end

  // receive occupancy after the request
  always_comb begin
    if (rx_head_next >= rx_tail_next) begin
      count_next = {1'b0, rx_head_next} - {1'b0, rx_tail_next};
    end else begin
      count_next = {1'b0, rx_head_next} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rx_tail_next};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head    <= '0;
      rx_tail    <= '0;
      tx_head    <= '0;
      tx_tail    <= '0;
      last_error <= urtb_pkg::ST_OK;
      tx_irq_on  <= 1'b0;
    end else if (cmd.exec) begin
      rx_head    <= rx_head_next;
      rx_tail    <= rx_tail_next;
      tx_head    <= tx_head_next;
      tx_tail    <= tx_tail_next;
      last_error <= last_error_next;
      tx_irq_on  <= tx_irq_on_next;
    end
  end

  // receive queue storage, registered read at the new tail
  always_ff @(posedge clk) begin
    if (cmd.exec && rx_wr) rx_store[rx_head_inc] <= data_byte;
    if (cmd.exec && rx_rd) rx_rdata <= rx_store[rx_tail_inc];
  end

  // transmit queue storage, registered read at the new tail
  always_ff @(posedge clk) begin
    if (cmd.exec && tx_wr) tx_store[tx_head_inc] <= data_byte;
    if (cmd.exec && tx_rd) tx_rdata <= tx_store[tx_tail_inc];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_sel         <= rx_rd;
      tx_sel         <= tx_rd;
      status         <= status_next;
      rx_count       <= 4'(count_next);
      write_accepted <= tx_wr;
    end
  end

  assign read_data     = rd_sel ? rx_rdata : 8'h00;
  assign tx_byte       = tx_sel ? tx_rdata : 8'h00;
  assign tx_valid      = tx_sel;
  assign tx_irq_enable = tx_irq_on;

endmodule

// File: sim/tb.sv
module tb;

  localparam int DEPTH        = urtb_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    logic       fe;
    logic       dor;
  } request_t;

  // field order matches the concatenation of the result ports
  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] status;
    logic [3:0] rx_count;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_irq;
    logic       wr_ok;
  } ring_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] operation = urtb_pkg::OP_LINE_RX;
  logic [7:0] data_byte = 8'h00;
  logic       framing_error = 1'b0;
  logic       overrun_error = 1'b0;
  logic       busy;
  logic       done;
  logic [7:0] read_data;
  logic [2:0] status;
  logic [3:0] rx_count;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_irq_enable;
  logic       write_accepted;

  uart_rx_tx_ring_buffers #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .data_byte(data_byte),
    .framing_error(framing_error),
    .overrun_error(overrun_error),
    .done(done),
    .read_data(read_data),
    .status(status),
    .rx_count(rx_count),
    .tx_valid(tx_valid),
    .tx_byte(tx_byte),
    .tx_irq_enable(tx_irq_enable),
    .write_accepted(write_accepted)
  );

  request_t     pending_requests[$];
  ring_result_t expected_results[$];
  int           total_requests = 0;
  int           accepted_count = 0;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           gap_left = 0;
  int           burst_left = 1;

  // shadow copy of both ring queues
  logic [7:0] rx_slots[DEPTH];
  logic [7:0] tx_slots[DEPTH];
  int         rx_wr = 0;
  int         rx_rd = 0;
  int         tx_wr = 0;
  int         tx_rd = 0;
  logic [2:0] err_latch = urtb_pkg::ST_OK;
  logic       irq_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // advance the shadow queues by one request and return its result
  function automatic ring_result_t ring_step(request_t r);
    ring_result_t res;
    int nxt;
    res = '0;
    res.status = urtb_pkg::ST_OK;
    case (r.op)
      urtb_pkg::OP_LINE_RX: begin
        nxt = (rx_wr + 1) % DEPTH;
        if (nxt == rx_rd) begin
          err_latch = urtb_pkg::ST_OVERFLOW;
        end else begin
          rx_slots[nxt] = r.data;
          rx_wr = nxt;
          err_latch = {1'b0, r.dor, r.fe};
        end
        res.status = err_latch;
      end
      urtb_pkg::OP_HOST_RD: begin
        if (rx_wr == rx_rd) begin
          res.status = urtb_pkg::ST_NO_DATA;
        end else begin
          rx_rd = (rx_rd + 1) % DEPTH;
          res.read_data = rx_slots[rx_rd];
          res.status = err_latch;
        end
      end
      urtb_pkg::OP_HOST_WR: begin
        nxt = (tx_wr + 1) % DEPTH;
        if (nxt != tx_rd) begin
          tx_slots[nxt] = r.data;
          tx_wr = nxt;
          irq_on = 1'b1;
          res.wr_ok = 1'b1;
        end
      end
      default: begin
        if (tx_wr != tx_rd) begin
          tx_rd = (tx_rd + 1) % DEPTH;
          res.tx_byte = tx_slots[tx_rd];
          res.tx_valid = 1'b1;
        end else begin
          irq_on = 1'b0;
        end
      end
    endcase
    res.rx_count = 4'((rx_wr + DEPTH - rx_rd) % DEPTH);
    res.tx_irq = irq_on;
    return res;
  endfunction

  task automatic add_request(logic [1:0] op, logic [7:0] data, logic fe, logic dor);
    request_t r;
    r.op = op;
    r.data = data;
    r.fe = fe;
    r.dor = dor;
    pending_requests.push_back(r);
    total_requests++;
  endtask

  // one run of requests leaning toward a single operation
  task automatic add_run(logic [1:0] main_op, int len, int bias);
    logic [1:0] op;
    for (int i = 0; i < len; i++) begin
      op = ($urandom_range(0, 99) < bias) ? main_op : 2'($urandom_range(0, 3));
      add_request(op, 8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end
  endtask

  // request driver: bursts of requests with random gaps between them
  always @(posedge clk) begin
    logic take;
    if (rst) begin
      start <= 1'b0;
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      err_latch = urtb_pkg::ST_OK;
      irq_on = 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        expected_results.push_back(ring_step(pending_requests.pop_front()));
        accepted_count++;
      end
      // a request not yet taken stays on the ports
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          operation <= pending_requests[0].op;
          data_byte <= pending_requests[0].data;
          framing_error <= pending_requests[0].fe;
          overrun_error <= pending_requests[0].dor;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    ring_result_t got;
    ring_result_t want;
    if (!rst && done) begin
      got = {read_data, status, rx_count, tx_valid, tx_byte, tx_irq_enable, write_accepted};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result rd=%h st=%0d cnt=%0d txv=%b txb=%h irq=%b acc=%b",
                   got.read_data, got.status, got.rx_count, got.tx_valid, got.tx_byte,
                   got.tx_irq, got.wr_ok);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch exp rd=%h st=%0d cnt=%0d txv=%b txb=%h irq=%b acc=%b",
                     want.read_data, want.status, want.rx_count, want.tx_valid,
                     want.tx_byte, want.tx_irq, want.wr_ok);
            $display("         got rd=%h st=%0d cnt=%0d txv=%b txb=%h irq=%b acc=%b",
                     got.read_data, got.status, got.rx_count, got.tx_valid,
                     got.tx_byte, got.tx_irq, got.wr_ok);
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int kind;
    // directed: empty reads, every error combination, byte extremes, tx drain past empty
    add_request(urtb_pkg::OP_HOST_RD, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_LINE_RX, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_LINE_RX, 8'hff, 1'b1, 1'b0);
    add_request(urtb_pkg::OP_LINE_RX, 8'h55, 1'b0, 1'b1);
    add_request(urtb_pkg::OP_LINE_RX, 8'haa, 1'b1, 1'b1);
    add_request(urtb_pkg::OP_HOST_RD, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_HOST_RD, 8'hff, 1'b1, 1'b1);
    add_request(urtb_pkg::OP_LINE_RX, 8'h3c, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_HOST_RD, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_HOST_RD, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_HOST_RD, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_HOST_WR, 8'hff, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_HOST_WR, 8'h00, 1'b1, 1'b1);
    add_request(urtb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0);
    add_request(urtb_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0);

    // random: fill and drain runs push both queues to full and empty
    while (total_requests < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 4);
      case (kind)
        0: add_run(urtb_pkg::OP_LINE_RX, $urandom_range(8, 24), 90);
        1: add_run(urtb_pkg::OP_HOST_RD, $urandom_range(8, 24), 90);
        2: add_run(urtb_pkg::OP_HOST_WR, $urandom_range(8, 24), 90);
        3: add_run(urtb_pkg::OP_TX_READY, $urandom_range(8, 24), 90);
        default: add_run(urtb_pkg::OP_LINE_RX, $urandom_range(4, 20), 0);
      endcase
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_results.size() > 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0d results never arrived", expected_results.size());
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: uart_rx_tx_ring_buffers.f
design/urtb_pkg.sv
design/urtb_ctrl.sv
design/urtb_dpath.sv
design/uart_rx_tx_ring_buffers.sv
sim/tb.sv
